// ===== sv/sal_pkg.sv =====
// Shared types and codes for the sorted linked list block.
// Used by the channel interfaces and by the top level; depends on nothing.
package sal_pkg;

    // Widths fixed by the request and result formats.
    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]       func_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [STATUS_W-1:0]     status_t;

    // Operation codes; the unused code behaves as a search.
    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_DELETE = 2'd1;
    localparam func_t FUNC_SEARCH = 2'd2;

    // Result status codes.
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FULL      = 2'd1;
    localparam status_t STATUS_DUPLICATE = 2'd2;
    localparam status_t STATUS_NOT_FOUND = 2'd3;

endpackage

// ===== sv/sal_if.sv =====
// Valid/ready channel interfaces for requests and results of the sorted list.
// Depends on sal_pkg for the payload types.
interface sal_req_if
    import sal_pkg::*;
;
    logic  valid;
    logic  ready;
    func_t func;
    key_t  key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface sal_rsp_if
    import sal_pkg::*;
#(
    parameter int SLOT_W = 7
);
    logic              valid;
    logic              ready;
    status_t           status;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== sv/sorted_array_linked_list.sv =====
// A full insert is answered straight from idle. Every other request walks the list node by node
// up to the first key not below the request key (0 to DEPTH nodes) and decides; a successful
// insert or delete then relinks through its write states before the result is loaded.
// Throughput: one request at a time; the walk reads one node a cycle through the node memory.
// The next request is taken once the result is in the output register, which holds it.
// Reset empties the list and makes every node free at once; no clearing pass is needed.
// Sorted static linked list: node memories, walk sequencer and free list management.
// Depends on sal_pkg and on the channel interfaces in sal_if.sv.
module sorted_array_linked_list
    import sal_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    sal_req_if.sink   req,
    sal_rsp_if.source rsp
);

    // Pointer width holds the null code DEPTH; index width addresses the memories.
    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] NIL = PW'(DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WALK    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_INS_WR1 = 3'd3;
    localparam logic [2:0] S_INS_WR2 = 3'd4;
    localparam logic [2:0] S_DEL_WR1 = 3'd5;
    localparam logic [2:0] S_DEL_WR2 = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] list_head_reg, list_head_next;
    logic [PW-1:0] free_head_reg, free_head_next;
    logic [PW-1:0] fill_reg, fill_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] succ_reg, succ_next;
    logic          hit_reg, hit_next;
    func_t         func_reg, func_next;
    key_t          key_reg, key_next;
    status_t       res_status_reg, res_status_next;
    logic [PW-1:0] res_slot_reg, res_slot_next;
    logic          rsp_valid_reg, rsp_valid_next;
    status_t       rsp_status_reg, rsp_status_next;
    logic [PW-1:0] rsp_slot_reg, rsp_slot_next;

    // Node memories and their registered read side.
    key_t          key_mem  [DEPTH];
    logic [PW-1:0] link_mem [DEPTH];
    key_t          key_q;
    logic [PW-1:0] link_q;
    logic [PW-1:0] addr_q;
    logic          fresh_q;

    logic [PW-1:0] rd_addr;
    logic          link_we;
    logic          key_we;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] wr_data;
    logic [PW-1:0] link_eff;
    logic          rsp_load_ok;

    // Nodes at or above the fill mark have never been written, so their link is
    // taken as pointing at the following node.
    assign link_eff = fresh_q ? (addr_q + PW'(1)) : link_q;

    assign rsp_load_ok = !rsp_valid_reg || rsp.ready;

    // Memory access: one read and one write a cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (key_we)
        begin
            key_mem[wr_addr[AW-1:0]] <= key_reg;
        end
        key_q   <= key_mem[rd_addr[AW-1:0]];
        link_q  <= link_mem[rd_addr[AW-1:0]];
        addr_q  <= rd_addr;
        fresh_q <= (rd_addr >= fill_reg);
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working registers of the current request and the result.
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        succ_reg       <= succ_next;
        hit_reg        <= hit_next;
        func_reg       <= func_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
    end

    // Sequencer: walk the list one node a cycle, then relink on an insert or delete.
    always_comb
    begin
        state_next      = state_reg;
        list_head_next  = list_head_reg;
        free_head_next  = free_head_reg;
        fill_next       = fill_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        succ_next       = succ_reg;
        hit_next        = hit_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rd_addr         = free_head_reg;
        link_we         = 1'b0;
        key_we          = 1'b0;
        wr_addr         = free_head_reg;
        wr_data         = cur_reg;

        // The result beat leaves the output register.
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr   = list_head_reg;
                func_next = req.func;
                key_next  = req.key;
                prev_next = NIL;
                cur_next  = list_head_reg;
                hit_next  = 1'b0;
                if (req.valid)
                begin
                    if (req.func == FUNC_INSERT && free_head_reg >= NIL)
                    begin
                        res_status_next = STATUS_FULL;
                        res_slot_next   = NIL;
                        state_next      = S_RESP;
                    end
                    else if (list_head_reg >= NIL)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                rd_addr = link_eff;
                if (key_q >= key_reg)
                begin
                    hit_next   = (key_q == key_reg);
                    succ_next  = link_eff;
                    state_next = S_DECIDE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_eff;
                    if (link_eff >= NIL)
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                // Read the free head's link, needed by an insert.
                rd_addr = free_head_reg;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = STATUS_DUPLICATE;
                            res_slot_next   = cur_reg;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_INS_WR1;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            state_next = S_DEL_WR1;
                        end
                        else
                        begin
                            res_status_next = STATUS_NOT_FOUND;
                            res_slot_next   = NIL;
                            state_next      = S_RESP;
                        end
                    end
                    default:
                    begin
                        res_status_next = hit_reg ? STATUS_OK : STATUS_NOT_FOUND;
                        res_slot_next   = hit_reg ? cur_reg : NIL;
                        state_next      = S_RESP;
                    end
                endcase
            end

            S_INS_WR1:
            begin
                // The new node takes the key and points at the stopping node.
                link_we         = 1'b1;
                key_we          = 1'b1;
                wr_addr         = free_head_reg;
                wr_data         = cur_reg;
                free_head_next  = link_eff;
                if (free_head_reg == fill_reg)
                begin
                    fill_next = fill_reg + PW'(1);
                end
                res_status_next = STATUS_OK;
                res_slot_next   = free_head_reg;
                state_next      = S_INS_WR2;
            end

            S_INS_WR2:
            begin
                if (prev_reg < NIL)
                begin
                    link_we = 1'b1;
                    wr_addr = prev_reg;
                    wr_data = res_slot_reg;
                end
                else
                begin
                    list_head_next = res_slot_reg;
                end
                state_next = S_RESP;
            end

            S_DEL_WR1:
            begin
                // Unlink the found node from its predecessor or the head.
                if (prev_reg < NIL)
                begin
                    link_we = 1'b1;
                    wr_addr = prev_reg;
                    wr_data = succ_reg;
                end
                else
                begin
                    list_head_next = succ_reg;
                end
                state_next = S_DEL_WR2;
            end

            S_DEL_WR2:
            begin
                // Push the freed node onto the free list.
                link_we         = 1'b1;
                wr_addr         = cur_reg;
                wr_data         = free_head_reg;
                free_head_next  = cur_reg;
                res_status_next = STATUS_OK;
                res_slot_next   = cur_reg;
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (rsp_load_ok)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.slot   = rsp_slot_reg;

    // The list and free heads are always a node or null.
    a_heads_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        list_head_reg <= NIL && free_head_reg <= NIL)
        else $error("list or free head beyond null");

    // The fill mark never moves back.
    a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |=> fill_reg >= $past(fill_reg))
        else $error("fill mark decreased");

    // Every cycle of the walk looks at a real node.
    a_walk_on_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> cur_reg < NIL)
        else $error("walk on a null node");

    // A full store never reports a slot.
    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_status_reg == STATUS_FULL |-> rsp_slot_reg == NIL)
        else $error("full status with a slot");

    // A taken result beat clears the output unless a new result is loaded.
    a_rsp_drains: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp.ready && state_reg != S_RESP |=> !rsp_valid_reg)
        else $error("result beat repeated");

endmodule
